// File: hdl/equirect_to_perspective_map_top_defines.svh
// assertion macros for the equirect to perspective map top level
// expects clk and rst in scope at the point of use
`ifndef EQUIRECT_TO_PERSPECTIVE_MAP_TOP_DEFINES_SVH
`define EQUIRECT_TO_PERSPECTIVE_MAP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define E2P_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define E2P_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/e2p_pkg.sv
// shared types, constants and arithmetic steps for the equirect to perspective map
// no dependencies
`default_nettype none

package e2p_pkg;

  localparam int FRAC_BITS    = 6;
  localparam int DIM_BITS     = 13;
  localparam int FULL_BITS    = DIM_BITS + FRAC_BITS;
  localparam int DIV_STEPS    = 29;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 22;
  localparam int LAT          = 95;

  localparam logic signed [25:0] ANG_HALF    = 26'sd8388608;
  localparam logic signed [25:0] ANG_QUARTER = 26'sd4194304;

  typedef enum logic [2:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_VIEW_W  = 3'd2,
    REG_VIEW_H  = 3'd3,
    REG_TAN_H   = 3'd4,
    REG_TAN_V   = 3'd5,
    REG_YAW_COS = 3'd6,
    REG_YAW_SIN = 3'd7
  } reg_idx_t;

  // restoring divider lane: nq holds the unread dividend bits, then the quotient
  typedef struct packed {
    logic [12:0] rem;
    logic [28:0] nq;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
  } cordic_t;

  function automatic div_lane_t div_step(div_lane_t d, logic [12:0] den);
    logic [13:0] trial;
    div_lane_t   r;
    trial = {d.rem, d.nq[28]};
    r.neg = d.neg;
    if (trial >= {1'b0, den}) begin
      r.rem = 13'(trial - {1'b0, den});
      r.nq  = {d.nq[27:0], 1'b1};
    end else begin
      r.rem = trial[12:0];
      r.nq  = {d.nq[27:0], 1'b0};
    end
    return r;
  endfunction

  // arctangent of 2^-i, with pi as 2^23
  function automatic logic [21:0] arc_angle(int i);
    logic [21:0] a;
    case (i)
      0:       a = 22'd2097152;
      1:       a = 22'd1238021;
      2:       a = 22'd654136;
      3:       a = 22'd332050;
      4:       a = 22'd166669;
      5:       a = 22'd83416;
      6:       a = 22'd41718;
      7:       a = 22'd20860;
      8:       a = 22'd10430;
      9:       a = 22'd5215;
      10:      a = 22'd2608;
      11:      a = 22'd1304;
      12:      a = 22'd652;
      13:      a = 22'd326;
      14:      a = 22'd163;
      15:      a = 22'd81;
      16:      a = 22'd41;
      17:      a = 22'd20;
      18:      a = 22'd10;
      19:      a = 22'd5;
      20:      a = 22'd3;
      21:      a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // quarter turn into the right half plane
  function automatic cordic_t cordic_pre(logic signed [33:0] y, logic signed [33:0] x);
    cordic_t r;
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x[33]) begin
      if (!y[33]) begin
        r.x = y;
        r.y = -x;
        r.z = ANG_QUARTER;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -ANG_QUARTER;
      end
    end
    return r;
  endfunction

  // vectoring step; y at zero stays put, which matches stopping early
  function automatic cordic_t cordic_step(cordic_t c, int i);
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [25:0] cz;
    logic signed [25:0] a;
    cordic_t            r;
    cx = c.x;
    cy = c.y;
    cz = c.z;
    xs = cx >>> i;
    ys = cy >>> i;
    a  = $signed({4'b0000, arc_angle(i)});
    r  = c;
    if (cy != '0) begin
      if (!cy[33]) begin
        r.x = cx + ys;
        r.y = cy - xs;
        r.z = cz + a;
      end else begin
        r.x = cx - ys;
        r.y = cy + xs;
        r.z = cz - a;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/e2p_ifs.sv
// valid/ready channels: output pixel coordinate in, panorama coordinate out
// no dependencies
`default_nettype none

interface e2p_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_col;
  logic [11:0] out_row;
  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface e2p_src_if;
  logic        valid;
  logic        ready;
  logic [17:0] src_col_fx;
  logic [18:0] src_row_fx;
  modport source (output valid, output src_col_fx, output src_row_fx, input ready);
  modport sink   (input valid, input src_col_fx, input src_row_fx, output ready);
endinterface

`default_nettype wire

// File: hdl/equirect_to_perspective_map_top.sv
// equirect to perspective remap coordinate pipeline, top level
// depends on e2p_pkg, e2p_ifs and equirect_to_perspective_map_top_defines.svh
//
//   port       dir   role
//   pixel      sink  output pixel column and row, one beat per pixel
//   coord      src   panorama column and row, 6 fraction bits
//   cfg_*      in    register writes, index 0..7
//
// one beat in per cycle while the output is not stalled; the depth of the pipeline is
// set by the two 29 step dividers, the 31 step square root and the latitude
// cordic in series. a stalled output freezes every stage together.
// reset clears stage valid bits and restores register defaults, no clearing pass.
`default_nettype none
`include "equirect_to_perspective_map_top_defines.svh"

module equirect_to_perspective_map_top
  import e2p_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  e2p_pix_if.sink          pixel,
  e2p_src_if.source        coord
);

  typedef struct packed {
    logic [60:0]        v;
    logic [61:0]        res;
    logic signed [30:0] y;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [61:0] bitv;
    logic [61:0] trial;
    sq_t         r;
    bitv  = 62'd1 << (60 - 2 * k);
    trial = s.res + bitv;
    r     = s;
    if ({1'b0, s.v} >= trial) begin
      r.v   = 61'({1'b0, s.v} - trial);
      r.res = (s.res >> 1) + bitv;
    end else begin
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  logic [12:0]        src_w;
  logic [12:0]        src_h;
  logic [12:0]        view_w;
  logic [12:0]        view_h;
  logic [15:0]        tan_h;
  logic [15:0]        tan_v;
  logic signed [15:0] yaw_cos;
  logic signed [15:0] yaw_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w   <= 13'd1920;
      src_h   <= 13'd960;
      view_w  <= 13'd640;
      view_h  <= 13'd480;
      tan_h   <= 16'd19526;
      tan_v   <= 16'd14637;
      yaw_cos <= 16'sd16384;
      yaw_sin <= 16'sd0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SRC_W:   src_w   <= cfg_data[12:0];
        REG_SRC_H:   src_h   <= cfg_data[12:0];
        REG_VIEW_W:  view_w  <= cfg_data[12:0];
        REG_VIEW_H:  view_h  <= cfg_data[12:0];
        REG_TAN_H:   tan_h   <= cfg_data;
        REG_TAN_V:   tan_v   <= cfg_data;
        REG_YAW_COS: yaw_cos <= $signed(cfg_data);
        REG_YAW_SIN: yaw_sin <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic [LAT:1] vld;
  logic         advance;

  assign advance     = !vld[LAT] || coord.ready;
  assign pixel.ready = advance && !rst;
  assign coord.valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-1:1], pixel.valid};
    end
  end

  // a zero view size counts as one
  logic [12:0]        view_w_eff;
  logic [12:0]        view_h_eff;
  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic [14:0]        dx_mag;
  logic [14:0]        dy_mag;

  assign view_w_eff = (view_w == '0) ? 13'd1 : view_w;
  assign view_h_eff = (view_h == '0) ? 13'd1 : view_h;
  assign dx = $signed({2'b00, pixel.out_col, 1'b1}) - $signed({2'b00, view_w_eff});
  assign dy = $signed({2'b00, pixel.out_row, 1'b1}) - $signed({2'b00, view_h_eff});
  assign dx_mag = dx[14] ? 15'(-dx) : 15'(dx);
  assign dy_mag = dy[14] ? 15'(-dy) : 15'(dy);

  logic [12:0] s1_mx;
  logic [12:0] s1_my;
  logic        s1_nx;
  logic        s1_ny;

  div_lane_t dvx [0:DIV_STEPS];
  div_lane_t dvy [0:DIV_STEPS];

  // signed normalised coordinates after the divide
  logic signed [29:0] nx_s;
  logic signed [29:0] ny_s;

  assign nx_s = dvx[DIV_STEPS].neg ? -$signed({1'b0, dvx[DIV_STEPS].nq})
                                   : $signed({1'b0, dvx[DIV_STEPS].nq});
  assign ny_s = dvy[DIV_STEPS].neg ? -$signed({1'b0, dvy[DIV_STEPS].nq})
                                   : $signed({1'b0, dvy[DIV_STEPS].nq});

  logic signed [45:0] c1_pc;
  logic signed [45:0] c1_ps;
  logic signed [29:0] c1_ny;

  logic signed [46:0] sin_sh;
  logic signed [46:0] cos_sh;

  assign sin_sh = $signed({{17{yaw_sin[15]}}, yaw_sin, 14'd0});
  assign cos_sh = $signed({{17{yaw_cos[15]}}, yaw_cos, 14'd0});

  logic signed [46:0] c2_rx;
  logic signed [46:0] c2_rz;
  logic signed [46:0] c2_ry;

  logic [46:0] d1_ax;
  logic [46:0] d1_az;
  logic [46:0] d1_ay;
  logic        d1_sx;
  logic        d1_sz;
  logic        d1_sy;

  logic [46:0] d2_ax;
  logic [46:0] d2_az;
  logic [46:0] d2_ay;
  logic        d2_sx;
  logic        d2_sz;
  logic        d2_sy;
  logic [46:0] d2_big;

  logic [46:0] d3_ax;
  logic [46:0] d3_az;
  logic [46:0] d3_ay;
  logic        d3_sx;
  logic        d3_sz;
  logic        d3_sy;
  logic [4:0]  d3_sh;

  logic signed [30:0] d4_x;
  logic signed [30:0] d4_z;
  logic signed [30:0] d4_y;

  logic [46:0] big_next;
  logic [4:0]  sh_next;
  logic [29:0] mx_sh;
  logic [29:0] mz_sh;
  logic [29:0] my_sh;

  always_comb begin
    big_next = d1_ax;
    if (d1_az > big_next) big_next = d1_az;
    if (d1_ay > big_next) big_next = d1_ay;
  end

  // shift that brings the largest magnitude below 2^30
  always_comb begin
    sh_next = '0;
    for (int i = 30; i <= 46; i++) begin
      if (d2_big[i]) sh_next = 5'(i - 29);
    end
  end

  assign mx_sh = 30'(d3_ax >> d3_sh);
  assign mz_sh = 30'(d3_az >> d3_sh);
  assign my_sh = 30'(d3_ay >> d3_sh);

  logic signed [61:0] px_sq;
  logic signed [61:0] pz_sq;
  logic [59:0]        e1_sqx;
  logic [59:0]        e1_sqz;
  logic signed [30:0] e1_y;

  assign px_sq = d4_x * d4_x;
  assign pz_sq = d4_z * d4_z;

  sq_t     sq     [0:SQRT_STEPS];
  cordic_t lon_c  [0:CORDIC_STEPS];
  cordic_t lat_c  [0:CORDIC_STEPS];
  logic signed [25:0] lon_d [0:32];

  // clamp the angles and turn them into panorama offsets
  logic signed [25:0]  lon_cl;
  logic signed [25:0]  lat_cl;
  logic signed [25:0]  lon_off;
  logic signed [25:0]  lat_off;
  logic [FULL_BITS-1:0] full_w;
  logic [FULL_BITS-1:0] full_h;

  always_comb begin
    lon_cl = lon_d[32];
    if (lon_cl > ANG_HALF) lon_cl = ANG_HALF;
    if (lon_cl < -ANG_HALF) lon_cl = -ANG_HALF;
    lat_cl = lat_c[CORDIC_STEPS].z;
    if (lat_cl > ANG_QUARTER) lat_cl = ANG_QUARTER;
    if (lat_cl < -ANG_QUARTER) lat_cl = -ANG_QUARTER;
  end

  assign lon_off = lon_cl + ANG_HALF;
  assign lat_off = lat_cl + ANG_QUARTER;
  assign full_w  = {src_w, FRAC_BITS'(0)};
  assign full_h  = {src_h, FRAC_BITS'(0)};

  logic [FULL_BITS+24:0] f1_col_p;
  logic [FULL_BITS+23:0] f1_row_p;

  logic [FULL_BITS+24:0] col_sum;
  logic [FULL_BITS+23:0] row_sum;
  logic [FULL_BITS:0]    col_raw;
  logic [FULL_BITS:0]    col_wrap;
  logic [FULL_BITS:0]    row_raw;

  assign col_sum  = f1_col_p + (FULL_BITS + 25)'(23'd0 + (1 << 23));
  assign row_sum  = f1_row_p + (FULL_BITS + 24)'(1 << 22);
  assign col_raw  = (FULL_BITS + 1)'(col_sum >> 24);
  assign row_raw  = (FULL_BITS + 1)'(row_sum >> 23);
  assign col_wrap = (col_raw >= {1'b0, full_w}) ? col_raw - {1'b0, full_w} : col_raw;

  always_ff @(posedge clk) begin
    if (advance) begin
      // normalise
      s1_mx <= dx_mag[12:0];
      s1_my <= dy_mag[12:0];
      s1_nx <= dx[14];
      s1_ny <= dy[14];

      dvx[0].rem <= '0;
      dvx[0].nq  <= 29'(s1_mx * tan_h + (view_w_eff >> 1));
      dvx[0].neg <= s1_nx;
      dvy[0].rem <= '0;
      dvy[0].nq  <= 29'(s1_my * tan_v + (view_h_eff >> 1));
      dvy[0].neg <= s1_ny;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dvx[k] <= div_step(dvx[k-1], view_w_eff);
        dvy[k] <= div_step(dvy[k-1], view_h_eff);
      end

      // yaw rotation
      c1_pc <= yaw_cos * nx_s;
      c1_ps <= yaw_sin * nx_s;
      c1_ny <= ny_s;

      c2_rx <= c1_pc + sin_sh;
      c2_rz <= cos_sh - c1_ps;
      c2_ry <= $signed({{3{c1_ny[29]}}, c1_ny, 14'd0});

      // common range reduction, magnitudes truncated
      d1_ax <= c2_rx[46] ? 47'(-c2_rx) : 47'(c2_rx);
      d1_az <= c2_rz[46] ? 47'(-c2_rz) : 47'(c2_rz);
      d1_ay <= c2_ry[46] ? 47'(-c2_ry) : 47'(c2_ry);
      d1_sx <= c2_rx[46];
      d1_sz <= c2_rz[46];
      d1_sy <= c2_ry[46];

      d2_ax  <= d1_ax;
      d2_az  <= d1_az;
      d2_ay  <= d1_ay;
      d2_sx  <= d1_sx;
      d2_sz  <= d1_sz;
      d2_sy  <= d1_sy;
      d2_big <= big_next;

      d3_ax <= d2_ax;
      d3_az <= d2_az;
      d3_ay <= d2_ay;
      d3_sx <= d2_sx;
      d3_sz <= d2_sz;
      d3_sy <= d2_sy;
      d3_sh <= sh_next;

      d4_x <= d3_sx ? -$signed({1'b0, mx_sh}) : $signed({1'b0, mx_sh});
      d4_z <= d3_sz ? -$signed({1'b0, mz_sh}) : $signed({1'b0, mz_sh});
      d4_y <= d3_sy ? -$signed({1'b0, my_sh}) : $signed({1'b0, my_sh});

      // horizontal length, square root one result bit a stage
      e1_sqx <= px_sq[59:0];
      e1_sqz <= pz_sq[59:0];
      e1_y   <= d4_y;

      sq[0].v   <= 61'(e1_sqx) + 61'(e1_sqz);
      sq[0].res <= '0;
      sq[0].y   <= e1_y;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        sq[k] <= sqrt_step(sq[k-1], k - 1);
      end

      // longitude runs beside the square root
      lon_c[0] <= cordic_pre(34'(d4_x), 34'(d4_z));
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        lon_c[k] <= cordic_step(lon_c[k-1], k - 1);
      end
      lon_d[0] <= lon_c[CORDIC_STEPS].z;
      for (int k = 1; k <= 32; k++) begin
        lon_d[k] <= lon_d[k-1];
      end

      lat_c[0] <= cordic_pre(34'(sq[SQRT_STEPS].y),
                             $signed({3'b000, sq[SQRT_STEPS].res[30:0]}));
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        lat_c[k] <= cordic_step(lat_c[k-1], k - 1);
      end

      // scale to panorama pixels
      f1_col_p <= lon_off[24:0] * full_w;
      f1_row_p <= lat_off[23:0] * full_h;

      coord.src_col_fx <= col_wrap[17:0];
      coord.src_row_fx <= row_raw[18:0];
    end
  end

  `E2P_ASSERT_NEXT(a_stall_freezes, coord.valid && !coord.ready, $stable(vld), "valids moved")
  `E2P_ASSERT_NEXT(a_entry_beat, advance, vld[1] == $past(pixel.valid), "entry beat lost")

endmodule

`default_nettype wire

// File: tb/tb_equirect_to_perspective_map_top.sv
// self-checking testbench for the equirect to perspective remap coordinate pipeline
// depends on e2p_pkg, e2p_ifs and equirect_to_perspective_map_top
// a local fixed-point model predicts each panorama coordinate; random gaps on both channels
module tb_equirect_to_perspective_map_top;
  import e2p_pkg::*;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } pix_t;

  typedef struct packed {
    logic [17:0] col_fx;
    logic [18:0] row_fx;
  } coord_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  e2p_pix_if pix ();
  e2p_src_if crd ();

  equirect_to_perspective_map_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix),
    .coord     (crd)
  );

  // local copy of the register file
  logic [12:0] m_src_w, m_src_h, m_view_w, m_view_h;
  logic [15:0] m_tan_h, m_tan_v, m_cos, m_sin;

  pix_t   pending_px[$];
  coord_t expected_coord[$];
  int     mismatches;
  bit     calm;     // no idling on either side
  int     send_gap;
  int     recv_stall;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint scaled_coord(longint pos, logic [12:0] size, logic [15:0] tanv);
    longint d, sz, q;
    sz = (size == 0) ? 1 : longint'(size);
    d  = 2 * pos + 1 - sz;
    q  = ((d < 0 ? -d : d) * longint'(tanv) + sz / 2) / sz;
    return d < 0 ? -q : q;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 4194304;
      end else begin
        x = -y; y = t; z = -4194304;
      end
    end
    for (int i = 0; i < 22; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(arc_angle(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(arc_angle(i));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint trunc_mag(longint v, int s);
    longint m;
    m = (v < 0 ? -v : v) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic coord_t project_pixel(pix_t p);
    longint c, s, nx, ny, rx, rz, ry, big, lon, lat;
    longint unsigned h, full, colv, rowv;
    int sh;
    coord_t r;
    c  = longint'($signed(m_cos));
    s  = longint'($signed(m_sin));
    nx = scaled_coord(longint'(p.col), m_view_w, m_tan_h);
    ny = scaled_coord(longint'(p.row), m_view_h, m_tan_v);
    rx = c * nx + s * 16384;
    rz = c * 16384 - s * nx;
    ry = ny * 16384;
    big = rx < 0 ? -rx : rx;
    if ((rz < 0 ? -rz : rz) > big) big = rz < 0 ? -rz : rz;
    if ((ry < 0 ? -ry : ry) > big) big = ry < 0 ? -ry : ry;
    sh = 0;
    while ((big >>> sh) >= (64'sd1 <<< 30)) sh++;
    rx = trunc_mag(rx, sh);
    rz = trunc_mag(rz, sh);
    ry = trunc_mag(ry, sh);
    h  = root_floor(longint'(rx * rx) + longint'(rz * rz));
    lon = vector_angle(rx, rz);
    if (lon > 8388608) lon = 8388608;
    if (lon < -8388608) lon = -8388608;
    lat = vector_angle(ry, longint'(h));
    if (lat > 4194304) lat = 4194304;
    if (lat < -4194304) lat = -4194304;
    colv = 0;
    rowv = 0;
    if (m_src_w != 0) begin
      full = longint'(m_src_w) << FRAC_BITS;
      colv = (longint'(lon + 8388608) * full + 8388608) >> 24;
      if (colv >= full) colv = colv - full;
    end
    if (m_src_h != 0) begin
      full = longint'(m_src_h) << FRAC_BITS;
      rowv = (longint'(lat + 4194304) * full + 4194304) >> 23;
    end
    r.col_fx = colv[17:0];
    r.row_fx = rowv[18:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid   <= 1'b0;
      pix.out_col <= '0;
      pix.out_row <= '0;
      send_gap    <= 0;
    end else begin
      if (pix.valid && pix.ready)
        expected_coord.push_back(project_pixel('{pix.out_col, pix.out_row}));
      if (!pix.valid || pix.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          pix.valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          pix_t p;
          p = pending_px.pop_front();
          pix.valid   <= 1'b1;
          pix.out_col <= p.col;
          pix.out_row <= p.row;
          send_gap    <= pick_gap();
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      crd.ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (crd.valid && crd.ready) begin
        if (expected_coord.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat col %0d row %0d", crd.src_col_fx, crd.src_row_fx);
        end else begin
          coord_t e;
          e = expected_coord.pop_front();
          if (e.col_fx !== crd.src_col_fx || e.row_fx !== crd.src_row_fx) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected col %0d row %0d, got col %0d row %0d",
                       e.col_fx, e.row_fx, crd.src_col_fx, crd.src_row_fx);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        crd.ready  <= 1'b0;
      end else begin
        crd.ready  <= 1'b1;
        recv_stall <= pick_gap();
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_SRC_W:   m_src_w  = v[12:0];
      REG_SRC_H:   m_src_h  = v[12:0];
      REG_VIEW_W:  m_view_w = v[12:0];
      REG_VIEW_H:  m_view_h = v[12:0];
      REG_TAN_H:   m_tan_h  = v;
      REG_TAN_V:   m_tan_v  = v;
      REG_YAW_COS: m_cos    = v;
      default:     m_sin    = v;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_px.size() > 0 || pix.valid || expected_coord.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_view(logic [15:0] sw, logic [15:0] sh, logic [15:0] vw, logic [15:0] vh,
                           logic [15:0] th, logic [15:0] tv, logic [15:0] yc, logic [15:0] ys);
    wait_drained();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_VIEW_W, vw);
    write_reg(REG_VIEW_H, vh);
    write_reg(REG_TAN_H, th);
    write_reg(REG_TAN_V, tv);
    write_reg(REG_YAW_COS, yc);
    write_reg(REG_YAW_SIN, ys);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'd4096;
      2: return 16'd0;
      3: return 16'd8191;
      4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] pick_tan();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd65535;
      default: return 16'($urandom_range(4000, 30000));
    endcase
  endfunction

  task automatic add_random(int n);
    int wmax, hmax;
    pix_t p;
    wmax = (m_view_w == 0) ? 1 : (m_view_w > 4096 ? 4096 : int'(m_view_w));
    hmax = (m_view_h == 0) ? 1 : (m_view_h > 4096 ? 4096 : int'(m_view_h));
    repeat (n) begin
      if ($urandom_range(0, 9) < 8) begin
        p.col = 12'($urandom_range(0, wmax - 1));
        p.row = 12'($urandom_range(0, hmax - 1));
      end else begin
        p.col = 12'($urandom_range(0, 4095));
        p.row = 12'($urandom_range(0, 4095));
      end
      pending_px.push_back(p);
    end
  endtask

  initial begin
    logic [15:0] yc, ys;
    int a;
    mismatches = 0;
    calm      = 1'b1;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.out_col = '0;
    pix.out_row = '0;
    crd.ready = 1'b0;
    m_src_w = 13'd1920; m_src_h = 13'd960; m_view_w = 13'd640; m_view_h = 13'd480;
    m_tan_h = 16'd19526; m_tan_v = 16'd14637; m_cos = 16'd16384; m_sin = 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed beats under the reset settings, corners, centre and outside the view
    pending_px.push_back('{12'd0, 12'd0});
    pending_px.push_back('{12'd639, 12'd479});
    pending_px.push_back('{12'd0, 12'd479});
    pending_px.push_back('{12'd639, 12'd0});
    pending_px.push_back('{12'd320, 12'd240});
    pending_px.push_back('{12'd319, 12'd239});
    pending_px.push_back('{12'd4095, 12'd4095});
    pending_px.push_back('{12'd640, 12'd480});
    pending_px.push_back('{12'd2730, 12'd1365});

    // smallest sizes, zero fov and a null yaw pair
    load_view(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    pending_px.push_back('{12'd0, 12'd0});
    pending_px.push_back('{12'd4095, 12'd0});
    pending_px.push_back('{12'd0, 12'd4095});
    // zero view and source sizes, widest fov, looking backwards
    load_view(16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'hC000, 16'd0);
    pending_px.push_back('{12'd0, 12'd0});
    pending_px.push_back('{12'd4095, 12'd4095});
    pending_px.push_back('{12'd1, 12'd2});
    // largest sizes, quarter turns either way
    load_view(16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd65535, 16'd65535, 16'd0, 16'd16384);
    pending_px.push_back('{12'd0, 12'd0});
    pending_px.push_back('{12'd4095, 12'd4095});
    pending_px.push_back('{12'd2048, 12'd2047});
    load_view(16'd8191, 16'd8191, 16'd4096, 16'd4096, 16'd16384, 16'd16384, 16'd0, 16'hC000);
    pending_px.push_back('{12'd0, 12'd4095});
    pending_px.push_back('{12'd4095, 12'd0});
    pending_px.push_back('{12'd2048, 12'd2048});
    // yaw pair with the sign bits set and out of range
    load_view(16'd1920, 16'd960, 16'd640, 16'd480, 16'd19526, 16'd14637, 16'h8000, 16'h8000);
    pending_px.push_back('{12'd0, 12'd0});
    pending_px.push_back('{12'd639, 12'd479});

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 4))
        0: begin yc = 16'($urandom_range(0, 65535)); ys = 16'($urandom_range(0, 65535)); end
        1: begin yc = 16'd0; ys = 16'd0; end
        default: begin
          a  = $urandom_range(0, 16384);
          yc = $urandom_range(0, 1) ? 16'(a) : 16'(-a);
          ys = $urandom_range(0, 1) ? 16'(16384 - a) : 16'(a - 16384);
        end
      endcase
      load_view(pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_tan(), pick_tan(), yc, ys);
      calm = (ph % 4 == 3);
      add_random(ph == 0 ? 300 : 120);
    end
    calm = 1'b0;
    // back to the reset settings for a final stretch
    load_view(16'd1920, 16'd960, 16'd640, 16'd480, 16'd19526, 16'd14637, 16'd16384, 16'd0);
    add_random(30);

    wait_drained();
    if (mismatches == 0 && expected_coord.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/e2p_pkg.sv
hdl/e2p_ifs.sv
hdl/equirect_to_perspective_map_top.sv
tb/tb_equirect_to_perspective_map_top.sv
